/* src/assert_macros.svh */
// Assertion macros shared by the checker files.
// Needs clk and arst_n visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted
`define CHK_PROP(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Implication form of the above
`define CHK_IMPL(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

`endif

/* src/crc8fc_pkg.sv */
// Shared types, constants and the CRC-8 byte step for the frame checker.
// No dependencies.
package crc8fc_pkg;

	localparam logic [7:0] CRC_POLY    = 8'h1D;
	localparam logic [7:0] HDR_FIRST   = 8'hAA;
	localparam logic [7:0] HDR_SECOND  = 8'h55;
	localparam logic [8:0] COUNT_MAX   = 9'd256;
	localparam logic [8:0] SIZE_MIN    = 9'd3;
	localparam logic [8:0] SIZE_MAX_OK = 9'd255;
	localparam logic [8:0] POS_HDR0    = 9'd0;
	localparam logic [8:0] POS_HDR1    = 9'd1;
	localparam logic [8:0] POS_LEN     = 9'd2;

	// One received beat
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} beat_t;

	// One frame verdict
	typedef struct packed {
		logic       ok;
		logic [8:0] size;
	} result_t;

	// MSB-first CRC-8 update over one byte, zero-based polynomial form
	function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] v;
		v = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (v[7]) begin
				v = {v[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				v = {v[6:0], 1'b0};
			end
		end
		return v;
	endfunction

endpackage

/* src/crc8fc_in_stage.sv */
// Input register for the frame checker: holds one beat until the core takes it.
// Uses crc8fc_pkg.
module crc8fc_in_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          rx_byte,
	input  logic                frame_end,
	input  logic                advance,
	output logic                beat_valid,
	output crc8fc_pkg::beat_t   beat
);

	logic              valid_s1;
	crc8fc_pkg::beat_t beat_s1;

	// Hold off the sender only while a beat sits here and cannot move on
	assign in_stall = valid_s1 & ~advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload, no reset needed
	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			beat_s1.data <= rx_byte;
			beat_s1.last <= frame_end;
		end
	end

	assign beat_valid = valid_s1;
	assign beat       = beat_s1;

endmodule

/* src/crc8fc_core.sv */
// Frame tracking state and verdict logic: header, length, running CRC.
// Uses crc8fc_pkg.
module crc8fc_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  crc8fc_pkg::beat_t   beat,
	output crc8fc_pkg::result_t res
);

	logic [7:0] crc_q;
	logic [8:0] count_q;
	logic       hdr_good_q;
	logic [7:0] len_q;

	logic [8:0] size;
	logic       hdr_good;
	logic [7:0] len;

	// Byte position, header and length byte for this beat
	always_comb begin
		size     = count_q[8] ? crc8fc_pkg::COUNT_MAX : count_q + 9'd1;
		hdr_good = hdr_good_q
			& ~(count_q == crc8fc_pkg::POS_HDR0 && beat.data != crc8fc_pkg::HDR_FIRST)
			& ~(count_q == crc8fc_pkg::POS_HDR1 && beat.data != crc8fc_pkg::HDR_SECOND);
		len      = (count_q == crc8fc_pkg::POS_LEN) ? beat.data : len_q;
	end

	// Verdict, meaningful on the last beat
	assign res.size = size;
	assign res.ok   = hdr_good
		&& size >= crc8fc_pkg::SIZE_MIN && size <= crc8fc_pkg::SIZE_MAX_OK
		&& {1'b0, len} == size
		&& beat.data == crc_q;

	// State update; the last beat returns everything to reset values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q      <= 8'd0;
			count_q    <= 9'd0;
			hdr_good_q <= 1'b1;
			len_q      <= 8'd0;
		end else if (fire) begin
			if (beat.last) begin
				crc_q      <= 8'd0;
				count_q    <= 9'd0;
				hdr_good_q <= 1'b1;
				len_q      <= 8'd0;
			end else begin
				crc_q      <= crc8fc_pkg::crc8_next(crc_q, beat.data);
				count_q    <= size;
				hdr_good_q <= hdr_good;
				len_q      <= len;
			end
		end
	end

endmodule

/* src/crc8fc_out_stage.sv */
// Result register for the frame checker, holds a verdict until taken.
// Uses crc8fc_pkg.
module crc8fc_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  crc8fc_pkg::result_t res,
	output logic                advance,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                frame_ok,
	output logic [8:0]          frame_size
);

	logic                valid_q;
	crc8fc_pkg::result_t res_q;

	// Free when empty or being emptied this cycle
	assign advance = ~valid_q | ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign out_valid  = valid_q;
	assign frame_ok   = res_q.ok;
	assign frame_size = res_q.size;

endmodule

/* src/crc8_frame_checker.sv */
// Top level of the CRC-8 frame checker: input register, core, result register.
// Uses crc8fc_pkg, crc8fc_in_stage, crc8fc_core, crc8fc_out_stage.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------
//  in      | in_valid / in_stall  | rx_byte[7:0], frame_end
//  out     | out_valid / out_stall| frame_ok, frame_size[8:0]
//
// One byte per cycle sustained while in_stall is low; the CRC step is one 8-bit update per beat.
// A frame's verdict passes through the input register and then the result register before it is on the outputs.
// Only the last beat of a frame yields a result beat.
// in_stall rises only while the input register holds a beat and the result
// register is full and stalled.
// arst_n clears the handshake and frame state; payload registers keep data.
module crc8_frame_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       frame_end,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       frame_ok,
	output logic [8:0] frame_size
);

	logic                advance;
	logic                beat_valid;
	logic                fire;
	crc8fc_pkg::beat_t   beat;
	crc8fc_pkg::result_t res;

	crc8fc_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.rx_byte    (rx_byte),
		.frame_end  (frame_end),
		.advance    (advance),
		.beat_valid (beat_valid),
		.beat       (beat)
	);

	// Beat is processed when the result side can take a verdict
	assign fire = beat_valid & advance;

	crc8fc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.beat   (beat),
		.res    (res)
	);

	crc8fc_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (fire & beat.last),
		.res        (res),
		.advance    (advance),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.frame_ok   (frame_ok),
		.frame_size (frame_size)
	);

endmodule

/* src/crc8fc_checker.sv */
// Port-level checks for the frame checker, bound to the top level.
// Uses assert_macros.svh.
`include "assert_macros.svh"

module crc8fc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       frame_end,
	input logic       out_valid,
	input logic       out_stall,
	input logic       frame_ok,
	input logic [8:0] frame_size
);

	// Stalled result beat holds
	`CHK_PROP(a_out_hold, out_valid && out_stall |=> out_valid && $stable(frame_ok) && $stable(frame_size), "result beat changed while stalled")

	// Input backpressure only comes from a stalled result
	`CHK_IMPL(a_stall_cause, in_stall, out_valid && out_stall, "in_stall without stalled output")

	// A good verdict implies a legal frame size
	`CHK_IMPL(a_ok_size, out_valid && frame_ok, frame_size >= 9'd3 && frame_size <= 9'd255, "frame_ok with illegal size")

	// A fresh result follows an accepted last beat
	`CHK_IMPL(a_rose_src, $rose(out_valid), $past(in_valid && !in_stall && frame_end, 2), "result without a last beat")

endmodule

bind crc8_frame_checker crc8fc_checker u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.frame_end  (frame_end),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.frame_ok   (frame_ok),
	.frame_size (frame_size)
);
